FILE: sv/address_name_cache_lru_top_defines.svh
// Assertion macros for the cache RTL.
`ifndef ADDRESS_NAME_CACHE_LRU_TOP_DEFINES_SVH
`define ADDRESS_NAME_CACHE_LRU_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ANC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("anc: same-cycle check failed");
`define ANC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("anc: next-cycle check failed");
`else
`define ANC_ASSERT_IMP(lbl, ante, cons)
`define ANC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: sv/anc_pkg.sv
`default_nettype none

package anc_pkg;

    localparam int ENTRIES = 128;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 64;
    localparam int NOW_W   = 32;
    localparam int SLOT_W  = 7;

    typedef enum logic [0:0] {
        ACT_PUT = 1'b0,
        ACT_GET = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              found;
        logic [IDX_W-1:0]  found_idx;
        logic [VAL_W-1:0]  value;
        logic              empty_valid;
        logic [IDX_W-1:0]  empty_idx;
        logic [TIME_W-1:0] min_time;
        logic [IDX_W-1:0]  oldest_idx;
    } probe_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] stamp;
    } wr_t;

    // True when tick a lies strictly before tick b, modulo 2^TIME_W.
    function automatic logic tick_before(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        begin
            d = a - b;
            return d[TIME_W-1];
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/anc_cell.sv
`default_nettype none

module anc_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [anc_pkg::IDX_W-1:0] cell_idx,
    input  wire logic                    probe_valid_in,
    input  wire anc_pkg::probe_t         probe_in,
    input  wire anc_pkg::wr_t            wr,
    output logic                         probe_valid_out,
    output anc_pkg::probe_t              probe_out
);

    logic [anc_pkg::KEY_W-1:0]  key_reg;
    logic [anc_pkg::TIME_W-1:0] time_reg;
    logic [anc_pkg::VAL_W-1:0]  value_reg;
    logic                       valid_reg;
    anc_pkg::probe_t            probe_reg;
    anc_pkg::probe_t            probe_next;
    logic                       wr_hit;

    assign wr_hit = wr.en && (wr.idx == cell_idx);

    always_comb
    begin
        probe_next = probe_in;
        if (!probe_in.found)
        begin
            if (key_reg == probe_in.key)
            begin
                probe_next.found     = 1'b1;
                probe_next.found_idx = cell_idx;
                probe_next.value     = value_reg;
            end
            else
            begin
                if ((key_reg == '0) && !probe_in.empty_valid)
                begin
                    probe_next.empty_valid = 1'b1;
                    probe_next.empty_idx   = cell_idx;
                end
                if ((cell_idx == '0) || anc_pkg::tick_before(time_reg, probe_in.min_time))
                begin
                    probe_next.min_time   = time_reg;
                    probe_next.oldest_idx = cell_idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            time_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= probe_valid_in;
            if (wr_hit)
            begin
                key_reg  <= wr.key;
                time_reg <= wr.stamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            value_reg <= wr.value;
        end
        if (probe_valid_in)
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_valid_out = valid_reg;
    assign probe_out       = probe_reg;

endmodule

`default_nettype wire

FILE: sv/address_name_cache_lru_top.sv
// Address-to-name cache with oldest-timestamp replacement.
// Input channel (in_valid/in_ready) carries action, key_address, name_value
// and now_tick; output channel (out_valid/out_ready) returns hit, name_out,
// slot, evicted and ignored, one result per input transfer.
// Entries sit in a row of 128 cells. A lookup probe enters cell 0 on the
// input transfer and moves one cell per cycle, collecting the key match,
// the first empty slot and the oldest timestamp on its way.
// A put writes its entry in the cycle the probe leaves the row.
// An item dropped for a zero key, or a put with a zero value, skips the
// scan and its result is loaded straight into the result register.
// One item is in the block at a time: a new input transfer is taken once
// the previous result has moved to the output register, so the block
// takes no new item while one is scanned or waits for that register.
// If the receiver stalls, the result waits in the output register and the
// block still takes and scans the next item, then holds its result until
// the output register frees.
// Reset empties every entry and zeroes every timestamp at once.
`default_nettype none
`include "address_name_cache_lru_top_defines.svh"

module address_name_cache_lru_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      action,
    input  wire logic [anc_pkg::KEY_W-1:0] key_address,
    input  wire logic [anc_pkg::VAL_W-1:0] name_value,
    input  wire logic [anc_pkg::NOW_W-1:0] now_tick,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           hit,
    output logic [anc_pkg::VAL_W-1:0]      name_out,
    output logic [anc_pkg::SLOT_W-1:0]     slot,
    output logic                           evicted,
    output logic                           ignored
);

    anc_pkg::state_t            state_reg;
    anc_pkg::state_t            state_next;
    logic                       accept;
    logic                       in_ignored;
    logic                       res_load;
    logic                       out_load;

    logic                       act_reg;
    logic [anc_pkg::KEY_W-1:0]  key_reg;
    logic [anc_pkg::VAL_W-1:0]  val_reg;
    logic [anc_pkg::TIME_W-1:0] time_reg;

    logic [anc_pkg::ENTRIES:0]  valid_chain;
    anc_pkg::probe_t            probe_chain [anc_pkg::ENTRIES+1];
    anc_pkg::probe_t            tail;
    logic                       tail_valid;
    anc_pkg::wr_t               wr;
    logic [anc_pkg::IDX_W-1:0]  target;

    logic                       res_hit_reg;
    logic [anc_pkg::VAL_W-1:0]  res_name_reg;
    logic [anc_pkg::SLOT_W-1:0] res_slot_reg;
    logic                       res_evicted_reg;
    logic                       res_ignored_reg;
    logic                       res_hit_next;
    logic [anc_pkg::VAL_W-1:0]  res_name_next;
    logic [anc_pkg::SLOT_W-1:0] res_slot_next;
    logic                       res_evicted_next;
    logic                       res_ignored_next;

    logic                       out_valid_reg;
    logic                       hit_reg;
    logic [anc_pkg::VAL_W-1:0]  name_out_reg;
    logic [anc_pkg::SLOT_W-1:0] slot_reg;
    logic                       evicted_reg;
    logic                       ignored_reg;

    assign accept     = in_valid && in_ready;
    assign in_ignored = (key_address == '0)
                        || ((action == anc_pkg::ACT_PUT) && (name_value == '0));

    assign valid_chain[0] = accept && !in_ignored;

    always_comb
    begin
        probe_chain[0]             = '0;
        probe_chain[0].key         = key_address;
        probe_chain[0].empty_valid = 1'b0;
        probe_chain[0].found       = 1'b0;
    end

    for (genvar i = 0; i < anc_pkg::ENTRIES; i++)
    begin : g_cell
        anc_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .cell_idx        (anc_pkg::IDX_W'(i)),
            .probe_valid_in  (valid_chain[i]),
            .probe_in        (probe_chain[i]),
            .wr              (wr),
            .probe_valid_out (valid_chain[i+1]),
            .probe_out       (probe_chain[i+1])
        );
    end

    assign tail       = probe_chain[anc_pkg::ENTRIES];
    assign tail_valid = valid_chain[anc_pkg::ENTRIES];

    assign target = tail.found       ? tail.found_idx :
                    tail.empty_valid ? tail.empty_idx : tail.oldest_idx;

    always_comb
    begin
        wr.en    = (state_reg == anc_pkg::S_SCAN) && tail_valid
                   && (act_reg == anc_pkg::ACT_PUT);
        wr.idx   = target;
        wr.key   = key_reg;
        wr.value = val_reg;
        wr.stamp = time_reg;
    end

    always_comb
    begin
        res_hit_next     = 1'b0;
        res_name_next    = '0;
        res_slot_next    = '0;
        res_evicted_next = 1'b0;
        res_ignored_next = 1'b0;
        if (state_reg == anc_pkg::S_IDLE)
        begin
            res_ignored_next = 1'b1;
        end
        else if (act_reg == anc_pkg::ACT_PUT)
        begin
            res_hit_next     = tail.found;
            res_slot_next    = anc_pkg::SLOT_W'(target);
            res_evicted_next = !tail.found && !tail.empty_valid;
        end
        else if (tail.found)
        begin
            res_hit_next  = 1'b1;
            res_name_next = tail.value;
            res_slot_next = anc_pkg::SLOT_W'(tail.found_idx);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        res_load   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            anc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_load   = in_ignored;
                    state_next = in_ignored ? anc_pkg::S_DONE : anc_pkg::S_SCAN;
                end
            end
            anc_pkg::S_SCAN:
            begin
                if (tail_valid)
                begin
                    res_load   = 1'b1;
                    state_next = anc_pkg::S_DONE;
                end
            end
            anc_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = anc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = anc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= anc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            key_reg  <= key_address;
            val_reg  <= name_value;
            time_reg <= anc_pkg::TIME_W'(now_tick);
        end
        if (res_load)
        begin
            res_hit_reg     <= res_hit_next;
            res_name_reg    <= res_name_next;
            res_slot_reg    <= res_slot_next;
            res_evicted_reg <= res_evicted_next;
            res_ignored_reg <= res_ignored_next;
        end
        if (out_load)
        begin
            hit_reg      <= res_hit_reg;
            name_out_reg <= res_name_reg;
            slot_reg     <= res_slot_reg;
            evicted_reg  <= res_evicted_reg;
            ignored_reg  <= res_ignored_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign name_out  = name_out_reg;
    assign slot      = slot_reg;
    assign evicted   = evicted_reg;
    assign ignored   = ignored_reg;

    `ANC_ASSERT_IMP(a_tail_in_scan, tail_valid, state_reg == anc_pkg::S_SCAN)
    `ANC_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != anc_pkg::S_IDLE)
    `ANC_ASSERT_IMP(a_single_probe, state_reg == anc_pkg::S_SCAN, $onehot0(valid_chain))
    `ANC_ASSERT_IMP(a_evict_put_miss, out_valid && evicted, !hit && !ignored && (name_out == '0))

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int POOL_SIZE  = 200;
    localparam int ITEM_COUNT = 1800;

    typedef struct {
        logic                       hit;
        logic [anc_pkg::VAL_W-1:0]  name;
        logic [anc_pkg::SLOT_W-1:0] slot;
        logic                       evicted;
        logic                       ignored;
    } cache_reply_t;

    class cache_scoreboard;
        logic [anc_pkg::KEY_W-1:0]  key_tab [anc_pkg::ENTRIES];
        logic [anc_pkg::VAL_W-1:0]  val_tab [anc_pkg::ENTRIES];
        logic [anc_pkg::TIME_W-1:0] stamp_tab [anc_pkg::ENTRIES];
        cache_reply_t               pending_replies [$];
        int                         errors;

        function new();
            foreach (key_tab[i])
            begin
                key_tab[i]   = '0;
                val_tab[i]   = '0;
                stamp_tab[i] = '0;
            end
            errors = 0;
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        // A stamp lies strictly before another when their difference,
        // taken modulo the stamp width, has its top bit set.
        function bit stamp_older(logic [anc_pkg::TIME_W-1:0] a,
                                 logic [anc_pkg::TIME_W-1:0] b);
            logic [anc_pkg::TIME_W-1:0] diff;
            diff = a - b;
            return diff[anc_pkg::TIME_W-1];
        endfunction

        function void note_request(anc_pkg::action_t act, logic [anc_pkg::KEY_W-1:0] key,
                                   logic [anc_pkg::VAL_W-1:0] val,
                                   logic [anc_pkg::NOW_W-1:0] tick);
            cache_reply_t               r;
            bit                         found;
            bit                         have_empty;
            int                         empty_idx;
            int                         oldest_idx;
            int                         target;
            logic [anc_pkg::TIME_W-1:0] oldest_stamp;
            r = '{hit: 1'b0, name: '0, slot: '0, evicted: 1'b0, ignored: 1'b0};
            found = 0;
            have_empty = 0;
            empty_idx = 0;
            oldest_idx = 0;
            target = 0;
            oldest_stamp = stamp_tab[0];
            if (act == anc_pkg::ACT_PUT)
            begin
                if (key == '0 || val == '0)
                    r.ignored = 1'b1;
                else
                begin
                    for (int i = 0; i < anc_pkg::ENTRIES; i++)
                    begin
                        if (key_tab[i] == key)
                        begin
                            found = 1;
                            target = i;
                            break;
                        end
                        if (key_tab[i] == '0 && !have_empty)
                        begin
                            have_empty = 1;
                            empty_idx = i;
                        end
                        if (i > 0 && stamp_older(stamp_tab[i], oldest_stamp))
                        begin
                            oldest_stamp = stamp_tab[i];
                            oldest_idx = i;
                        end
                    end
                    if (found)
                        r.hit = 1'b1;
                    else if (have_empty)
                        target = empty_idx;
                    else
                    begin
                        target = oldest_idx;
                        r.evicted = 1'b1;
                    end
                    key_tab[target]   = key;
                    val_tab[target]   = val;
                    stamp_tab[target] = anc_pkg::TIME_W'(tick);
                    r.slot = anc_pkg::SLOT_W'(target);
                end
            end
            else
            begin
                if (key == '0)
                    r.ignored = 1'b1;
                else
                begin
                    for (int i = 0; i < anc_pkg::ENTRIES; i++)
                    begin
                        if (key_tab[i] == key)
                        begin
                            r.hit  = 1'b1;
                            r.name = val_tab[i];
                            r.slot = anc_pkg::SLOT_W'(i);
                            break;
                        end
                    end
                end
            end
            pending_replies.push_back(r);
        endfunction

        task check_reply(logic got_hit, logic [anc_pkg::VAL_W-1:0] got_name,
                         logic [anc_pkg::SLOT_W-1:0] got_slot, logic got_evicted,
                         logic got_ignored);
            cache_reply_t e;
            if (pending_replies.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            e = pending_replies.pop_front();
            if (got_hit !== e.hit)
                report($sformatf("hit %b, expected %b", got_hit, e.hit));
            if (got_name !== e.name)
                report($sformatf("name_out %h, expected %h", got_name, e.name));
            if (got_slot !== e.slot)
                report($sformatf("slot %0d, expected %0d", got_slot, e.slot));
            if (got_evicted !== e.evicted)
                report($sformatf("evicted %b, expected %b", got_evicted, e.evicted));
            if (got_ignored !== e.ignored)
                report($sformatf("ignored %b, expected %b", got_ignored, e.ignored));
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       action = 1'b0;
    logic [anc_pkg::KEY_W-1:0]  key_address = '0;
    logic [anc_pkg::VAL_W-1:0]  name_value = '0;
    logic [anc_pkg::NOW_W-1:0]  now_tick = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       hit;
    logic [anc_pkg::VAL_W-1:0]  name_out;
    logic [anc_pkg::SLOT_W-1:0] slot;
    logic                       evicted;
    logic                       ignored;

    cache_scoreboard            model = new();
    bit                         steady = 0;
    logic [anc_pkg::NOW_W-1:0]  tick_base = 32'hFFFF_FC00;
    logic [anc_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];

    address_name_cache_lru_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .key_address (key_address),
        .name_value  (name_value),
        .now_tick    (now_tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .name_out    (name_out),
        .slot        (slot),
        .evicted     (evicted),
        .ignored     (ignored)
    );

    always #6 clk = ~clk;

    function automatic bit take_pause();
        return !steady && ($urandom_range(99) < 31);
    endfunction

    // Ticks mostly creep forward across the wrap point, with rare far jumps.
    function automatic logic [anc_pkg::NOW_W-1:0] next_tick();
        if ($urandom_range(99) < 2)
            return $urandom;
        tick_base = tick_base + $urandom_range(3);
        return tick_base;
    endfunction

    function automatic logic [anc_pkg::VAL_W-1:0] random_name();
        logic [anc_pkg::VAL_W-1:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(49) == 0)
            v = '1;
        if (v == '0)
            v = anc_pkg::VAL_W'(1);
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(anc_pkg::action_t act, logic [anc_pkg::KEY_W-1:0] key,
                                logic [anc_pkg::VAL_W-1:0] val,
                                logic [anc_pkg::NOW_W-1:0] tick);
        while (take_pause())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        key_address <= key;
        name_value  <= val;
        now_tick    <= tick;
        do
            @(posedge clk);
        while (!in_ready);
        model.note_request(act, key, val, tick);
        @(negedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                model.check_reply(hit, name_out, slot, evicted, ignored);
            @(negedge clk);
            out_ready <= !take_pause();
        end
    end

    initial
    begin
        #(20_000_000);
        model.report($sformatf("timeout with %0d results outstanding",
                               model.pending_replies.size()));
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int                        sent;
        int                        pick;
        logic [anc_pkg::KEY_W-1:0] k;
        logic [anc_pkg::VAL_W-1:0] v;

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            k = $urandom;
            key_pool[i] = (k == '0) ? 32'h1 : k;
        end
        key_pool[0] = '1;
        key_pool[1] = 32'h1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(anc_pkg::ACT_GET, 32'h1, '0, '0);
        send_request(anc_pkg::ACT_PUT, '0, 64'h1234, 32'h10);
        send_request(anc_pkg::ACT_PUT, 32'hC0A8_0001, '0, 32'h11);
        send_request(anc_pkg::ACT_GET, '0, '1, '1);
        send_request(anc_pkg::ACT_PUT, '0, '0, '0);
        send_request(anc_pkg::ACT_PUT, '1, '1, '1);
        send_request(anc_pkg::ACT_PUT, 32'h1, 64'h1, '0);
        send_request(anc_pkg::ACT_GET, '1, '0, '0);
        send_request(anc_pkg::ACT_GET, 32'h1, '1, '1);
        send_request(anc_pkg::ACT_PUT, 32'h1, 64'h8000_0000_0000_0000, 32'h8000_0000);
        send_request(anc_pkg::ACT_GET, 32'h1, '0, '0);
        send_request(anc_pkg::ACT_PUT, 32'h8000_0000, 64'h5555_AAAA_5555_AAAA, 32'h7FFF_FFFF);
        send_request(anc_pkg::ACT_PUT, 32'h8000_0000, 64'hAAAA_5555_AAAA_5555, 32'h7FFF_FFFF);
        send_request(anc_pkg::ACT_GET, 32'h8000_0000, '1, '1);
        send_request(anc_pkg::ACT_GET, 32'h7FFF_FFFF, '1, '1);
        send_request(anc_pkg::ACT_PUT, 32'h0A00_0002, 64'h2, 32'h0);

        sent = 0;
        while (sent < ITEM_COUNT)
        begin
            steady = (sent >= 700 && sent < 1000);
            pick = $urandom_range(99);
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
            v = random_name();
            if (pick < 45)
                send_request(anc_pkg::ACT_PUT, k, v, next_tick());
            else if (pick < 85)
                send_request(anc_pkg::ACT_GET, k, v, $urandom);
            else if (pick < 90)
                send_request(anc_pkg::ACT_GET, $urandom, v, $urandom);
            else if (pick < 93)
                send_request(anc_pkg::ACT_PUT, k, '0, next_tick());
            else if (pick < 95)
                send_request(anc_pkg::ACT_PUT, '0, v, next_tick());
            else if (pick < 97)
                send_request(anc_pkg::ACT_GET, '0, v, $urandom);
            else
                send_request(anc_pkg::ACT_PUT, $urandom | 32'h1, v, next_tick());
            sent++;
        end
        steady = 0;
        in_valid <= 1'b0;

        while (model.pending_replies.size() != 0)
            @(posedge clk);
        repeat (2 * anc_pkg::ENTRIES) @(posedge clk);

        if (model.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
